>>> rtl/core/llt_pkg.sv
// Shared types and constants for the increasing-run length tail table.
package llt_pkg;

	// Field widths fixed by the interface
	localparam int VAL_W   = 32;
	localparam int RUN_W   = 11;

	// Default tail table depth
	localparam int MAX_LEN_DEF = 1024;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEEK,
		ST_STEP,
		ST_FINISH
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;    // input transfer: latch value, apply start
		logic seek;    // open the search, issue first probe
		logic step;    // compare probe data, narrow bounds
		logic finish;  // commit table update and load result
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic more;       // bounds still open before first probe
		logic step_more;  // bounds still open after this compare
	} status_t;

endpackage

>>> rtl/core/llt_ctrl.sv
// Controller state machine for the tail table search sequence.
module llt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  llt_pkg::status_t  status,
	output llt_pkg::cmd_t     cmd
);

	llt_pkg::state_t state_q;
	llt_pkg::state_t state_n;
	logic            out_valid_q;
	logic            out_free;

	// Result slot is free when empty or being drained this cycle
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == llt_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			llt_pkg::ST_IDLE: begin
				if (in_valid) state_n = llt_pkg::ST_SEEK;
			end
			llt_pkg::ST_SEEK: begin
				state_n = status.more ? llt_pkg::ST_STEP : llt_pkg::ST_FINISH;
			end
			llt_pkg::ST_STEP: begin
				state_n = status.step_more ? llt_pkg::ST_STEP : llt_pkg::ST_FINISH;
			end
			llt_pkg::ST_FINISH: begin
				if (out_free) state_n = llt_pkg::ST_IDLE;
			end
			default: begin
				state_n = llt_pkg::ST_IDLE;
			end
		endcase
	end

	// Command outputs
	always_comb begin
		cmd = '0;
		case (state_q)
			llt_pkg::ST_IDLE:   cmd.load   = in_valid;
			llt_pkg::ST_SEEK:   cmd.seek   = 1'b1;
			llt_pkg::ST_STEP:   cmd.step   = 1'b1;
			llt_pkg::ST_FINISH: cmd.finish = out_free;
			default:            cmd        = '0;
		endcase
	end

	// State and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= llt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/llt_datapath.sv
// Datapath: tail memory, lower-bound search bounds, count and result registers.
module llt_datapath #(
	parameter int MAX_LEN = llt_pkg::MAX_LEN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  llt_pkg::cmd_t                    cmd,
	output llt_pkg::status_t                 status,
	input  logic signed [llt_pkg::VAL_W-1:0] sample_value,
	input  logic                             start_new,
	output logic [llt_pkg::RUN_W-1:0]        run_length,
	output logic                             overflowed
);

	localparam int CW = $clog2(MAX_LEN + 1);  // count and bound width
	localparam int AW = $clog2(MAX_LEN);      // memory address width

	logic signed [llt_pkg::VAL_W-1:0] tail_mem [MAX_LEN];

	logic signed [llt_pkg::VAL_W-1:0] val_q;
	logic signed [llt_pkg::VAL_W-1:0] rdata_q;
	logic [CW-1:0]                    count_q;
	logic                             sticky_q;
	logic [CW-1:0]                    lo_q;
	logic [CW-1:0]                    hi_q;
	logic [CW-1:0]                    mid_q;
	logic [llt_pkg::RUN_W-1:0]        run_length_q;
	logic                             overflowed_q;

	logic [CW-1:0]                    cnt_eff;
	logic                             less;
	logic [CW-1:0]                    lo_n;
	logic [CW-1:0]                    hi_n;
	logic [CW-1:0]                    pa_lo;
	logic [CW-1:0]                    pa_hi;
	logic [CW:0]                      mid_sum;
	logic [CW-1:0]                    mid_n;
	logic                             rd_en;
	logic                             append;
	logic                             full;
	logic                             wr_en;
	logic [CW-1:0]                    count_n;
	logic                             sticky_n;
	logic [CW+llt_pkg::RUN_W-1:0]     run_ext;

	// Count after an optional start of a new sequence
	assign cnt_eff = start_new ? '0 : count_q;

	// One lower-bound step: probe below value moves lo past it
	assign less = (rdata_q < val_q);
	assign lo_n = less ? (mid_q + CW'(1)) : lo_q;
	assign hi_n = less ? hi_q : mid_q;

	// Probe address from current bounds (seek) or narrowed bounds (step)
	assign pa_lo   = cmd.step ? lo_n : lo_q;
	assign pa_hi   = cmd.step ? hi_n : hi_q;
	assign mid_sum = {1'b0, pa_lo} + {1'b0, pa_hi};
	assign mid_n   = mid_sum[CW:1];

	assign status.more      = (lo_q < hi_q);
	assign status.step_more = (lo_n < hi_n);

	assign rd_en = (cmd.seek && status.more) || (cmd.step && status.step_more);

	// Commit: search ended past the last tail means append
	assign append   = (lo_q == count_q);
	assign full     = (count_q == CW'(MAX_LEN));
	assign wr_en    = cmd.finish && !(append && full);
	assign count_n  = (append && !full) ? (count_q + CW'(1)) : count_q;
	assign sticky_n = sticky_q || (append && full);
	assign run_ext  = {{llt_pkg::RUN_W{1'b0}}, count_n};

	// Tail memory, one read and one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= tail_mem[mid_n[AW-1:0]];
		end
		if (wr_en) begin
			tail_mem[lo_q[AW-1:0]] <= val_q;
		end
	end

	// Search bounds, probe index, latched value and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= sample_value;
			lo_q  <= '0;
			hi_q  <= cnt_eff;
		end else if (cmd.step) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
		end
		if (rd_en) begin
			mid_q <= mid_n;
		end
		if (cmd.finish) begin
			run_length_q <= run_ext[llt_pkg::RUN_W-1:0];
			overflowed_q <= sticky_n;
		end
	end

	// Table count and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sticky_q <= 1'b0;
		end else if (cmd.load) begin
			count_q  <= cnt_eff;
			sticky_q <= sticky_q && !start_new;
		end else if (cmd.finish) begin
			count_q  <= count_n;
			sticky_q <= sticky_n;
		end
	end

	assign run_length = run_length_q;
	assign overflowed = overflowed_q;

endmodule

>>> rtl/core/lis_length_tail_table.sv
// Top level of the strictly increasing run length tail table.
//
// Each transfer carries one signed 32-bit value; start_new clears the table
// (and the overflow flag) before that value is taken. The block keeps the
// smallest tail for every run length and returns, per value, the longest
// strictly increasing subsequence length so far and a sticky overflow flag
// that is set when a value needed to be appended to a full table (the length
// then stays at MAX_LEN). One value is processed at a time: a lower-bound
// binary search over the stored tails makes one probe per cycle through the
// single read port of the tail memory, with at most ceil(log2(n + 1)) probes
// for n stored tails. A finished result waits in an output register while
// the next value is accepted. The tail memory needs no clearing after reset.
module lis_length_tail_table #(
	parameter int MAX_LEN = llt_pkg::MAX_LEN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [llt_pkg::VAL_W-1:0] sample_value,
	input  logic                             start_new,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [llt_pkg::RUN_W-1:0]        run_length,
	output logic                             overflowed
);

	llt_pkg::cmd_t    cmd;
	llt_pkg::status_t status;

	// Sequencer
	llt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Tail table and search datapath
	llt_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample_value (sample_value),
		.start_new    (start_new),
		.run_length   (run_length),
		.overflowed   (overflowed)
	);

endmodule
